// ===== hw/rtl/crc8_packet_framer_macros.svh =====
// Assertion macros for the CRC-8 packet framer
`ifndef CRC8_PACKET_FRAMER_MACROS_SVH
`define CRC8_PACKET_FRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CRC8PF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crc8 framer check failed");

// Next-cycle implication, disabled during reset
`define CRC8PF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crc8 framer check failed");

`endif

// ===== hw/rtl/crc8pf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package crc8pf_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hF1;
  localparam logic [BYTE_W-1:0] NODE_ADDRESS_RST = 8'h01;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'hF2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd2;

  typedef enum logic [2:0] {
    SLOT_START = 3'd0,
    SLOT_ADDR  = 3'd1,
    SLOT_LEN   = 3'd2,
    SLOT_DATA  = 3'd3,
    SLOT_CRC   = 3'd4,
    SLOT_END   = 3'd5
  } slot_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] node_address;
    logic [BYTE_W-1:0] end_marker;
  } cfg_t;

  // One accepted payload byte with its framing decisions
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] hdr_crc;
    logic              first;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] crc;
    logic              last;
  } burst_t;

  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/crc8pf_intake.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crc8pf_intake
  import crc8pf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] payload_byte,
  input  wire logic [BYTE_W-1:0] frame_length,
  input  wire logic [BYTE_W-1:0] addr_crc,
  output logic                   item_valid,
  output item_t                  item,
  input  wire logic              item_take
);

  logic              in_frame;
  logic [BYTE_W-1:0] bytes_left;
  logic              in_take;
  logic [BYTE_W-1:0] len_eff;
  logic [BYTE_W-1:0] left_next;
  item_t             item_next;

  assign in_stall = item_valid && !item_take;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    len_eff   = (frame_length == '0) ? BYTE_W'(1) : frame_length;
    left_next = (in_frame ? bytes_left : len_eff) - BYTE_W'(1);
    item_next.data    = payload_byte;
    item_next.len     = len_eff;
    item_next.hdr_crc = crc8_update(addr_crc, len_eff);
    item_next.first   = !in_frame;
    item_next.last    = (left_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      bytes_left <= '0;
      item_valid <= 1'b0;
    end else begin
      if (in_take) begin
        in_frame   <= (left_next != '0);
        bytes_left <= left_next;
        item_valid <= 1'b1;
      end else if (item_take) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= item_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/crc8pf_serializer.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crc8pf_serializer
  import crc8pf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              item_valid,
  input  wire item_t             item,
  output logic                   item_take,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   frame_done,
  output logic                   run_last
);

  burst_t            burst;
  slot_t             slot;
  logic [BYTE_W-1:0] crc_acc;
  logic [BYTE_W-1:0] crc_next;
  logic              out_take;

  assign out_take  = out_valid && !out_stall;
  assign run_last  = burst.last ? (slot == SLOT_END) : (slot == SLOT_DATA);
  assign item_take = item_valid && (!out_valid || (out_take && run_last));
  assign crc_next  = crc8_update(item.first ? item.hdr_crc : crc_acc, item.data);
  assign frame_done = (slot == SLOT_END);

  always_comb begin
    unique case (slot)
      SLOT_START: out_byte = cfg.start_marker;
      SLOT_ADDR:  out_byte = cfg.node_address;
      SLOT_LEN:   out_byte = burst.len;
      SLOT_DATA:  out_byte = burst.data;
      SLOT_CRC:   out_byte = burst.crc;
      SLOT_END:   out_byte = cfg.end_marker;
      default:    out_byte = burst.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot      <= SLOT_DATA;
      crc_acc   <= CRC_INIT;
    end else begin
      if (item_take) begin
        out_valid <= 1'b1;
        slot      <= item.first ? SLOT_START : SLOT_DATA;
        crc_acc   <= item.last ? CRC_INIT : crc_next;
      end else if (out_take) begin
        if (run_last) begin
          out_valid <= 1'b0;
        end else begin
          slot <= slot_t'(slot + 3'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      burst.data  <= item.data;
      burst.len   <= item.len;
      burst.crc   <= crc_next;
      burst.last  <= item.last;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/crc8_packet_framer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// CRC-8 packet framer. Each frame goes out as start marker, node address, length,
// payload bytes, CRC-8 (poly 0x31, init 0xFF, MSB first, over address, length and
// payload) and end marker. The first payload byte of a frame carries the length
// (0 counts as 1) and yields four output beats, a middle byte one, the last byte
// three more (six for a one-byte frame). Output runs at one beat per cycle from
// the serializer while out_stall is low, so input bytes are taken at one per
// cycle inside a frame and wait out the extra header and trailer beats. Each item
// passes the intake and serializer registers. Write configuration only while idle.
module crc8_packet_framer
  import crc8pf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BYTE_W-1:0]    payload_byte,
  input  wire logic [BYTE_W-1:0]    frame_length,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [BYTE_W-1:0]         out_byte,
  output logic                      frame_done,
  output logic                      run_last
);

`include "crc8_packet_framer_macros.svh"

  cfg_t              cfg;
  logic [BYTE_W-1:0] addr_crc;
  logic              item_valid;
  item_t             item;
  logic              item_take;

  // Keep the CRC of the address byte ready for the header
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker <= START_MARKER_RST;
      cfg.node_address <= NODE_ADDRESS_RST;
      cfg.end_marker   <= END_MARKER_RST;
      addr_crc         <= crc8_update(CRC_INIT, NODE_ADDRESS_RST);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_START_MARKER: cfg.start_marker <= cfg_data;
        CFG_NODE_ADDRESS: begin
          cfg.node_address <= cfg_data;
          addr_crc         <= crc8_update(CRC_INIT, cfg_data);
        end
        CFG_END_MARKER:   cfg.end_marker <= cfg_data;
        default: ;
      endcase
    end
  end

  crc8pf_intake u_intake (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .payload_byte (payload_byte),
    .frame_length (frame_length),
    .addr_crc     (addr_crc),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take)
  );

  crc8pf_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .frame_done (frame_done),
    .run_last   (run_last)
  );

  `CRC8PF_ASSERT_NOW(a_done_is_last, clk, rst, out_valid && frame_done, run_last)
  `CRC8PF_ASSERT_NEXT(a_burst_no_gap, clk, rst, out_valid && !out_stall && !run_last, out_valid)
  `CRC8PF_ASSERT_NOW(a_stall_needs_burst, clk, rst, in_stall, out_valid && item_valid)

endmodule
`default_nettype wire

// ===== tb/sv/crc8_packet_framer_tb.sv =====
`timescale 1ns / 1ps
module crc8_packet_framer_tb;
  import crc8pf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int ITEM_TARGET = 320;
  localparam int HOLD_AT_BEAT = 150;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [BYTE_W-1:0]   data;
    logic [BYTE_W-1:0]   len;
    logic                typed;
    logic [BYTE_W-1:0]   t_start;
    logic [BYTE_W-1:0]   t_addr;
    logic [BYTE_W-1:0]   t_len;
  } row_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              done;
    logic              last;
  } beat_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [BYTE_W-1:0]    payload_byte;
  logic [BYTE_W-1:0]    frame_length;
  logic                 out_valid;
  logic                 out_stall;
  logic [BYTE_W-1:0]    out_byte;
  logic                 frame_done;
  logic                 run_last;

  crc8_packet_framer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .payload_byte (payload_byte),
    .frame_length (frame_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .frame_done   (frame_done),
    .run_last     (run_last)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [BYTE_W-1:0] reg_start;
  logic [BYTE_W-1:0] reg_addr;
  logic [BYTE_W-1:0] reg_end;
  logic              fr_open;
  logic [BYTE_W-1:0] fr_left;
  logic [BYTE_W-1:0] fr_crc;

  beat_t pending_beats[$];
  int    errors = 0;
  int    items_sent = 0;
  logic  calm = 1'b0;

  row_t plan [20] = '{
    '{ROW_ITEM,  CFG_START_MARKER, 8'h00, 8'd1,   1'b1,
      START_MARKER_RST, NODE_ADDRESS_RST, 8'd1},
    '{ROW_ITEM,  CFG_START_MARKER, 8'hFF, 8'd0,   1'b1,
      START_MARKER_RST, NODE_ADDRESS_RST, 8'd1},
    '{ROW_ITEM,  CFG_START_MARKER, 8'hA5, 8'd3,   1'b1,
      START_MARKER_RST, NODE_ADDRESS_RST, 8'd3},
    '{ROW_ITEM,  CFG_START_MARKER, 8'h5A, 8'd200, 1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_ITEM,  CFG_START_MARKER, 8'h3C, 8'd0,   1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_WRITE, CFG_START_MARKER, 8'h00, 8'd0,   1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_WRITE, CFG_NODE_ADDRESS, 8'hFF, 8'd0,   1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_WRITE, CFG_END_MARKER,   8'h00, 8'd0,   1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_WRITE, CFG_SPARE,        8'hAA, 8'd0,   1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_ITEM,  CFG_START_MARKER, 8'h81, 8'd2,   1'b1, 8'h00, 8'hFF, 8'd2},
    '{ROW_ITEM,  CFG_START_MARKER, 8'h7E, 8'd255, 1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_WRITE, CFG_START_MARKER, 8'hFF, 8'd0,   1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_WRITE, CFG_NODE_ADDRESS, 8'h00, 8'd0,   1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_WRITE, CFG_END_MARKER,   8'hFF, 8'd0,   1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_ITEM,  CFG_START_MARKER, 8'h55, 8'd4,   1'b1, 8'hFF, 8'h00, 8'd4},
    '{ROW_ITEM,  CFG_START_MARKER, 8'hAA, 8'd1,   1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_WRITE, CFG_END_MARKER,   8'h5A, 8'd0,   1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_ITEM,  CFG_START_MARKER, 8'h01, 8'd0,   1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_ITEM,  CFG_START_MARKER, 8'h80, 8'd128, 1'b0, 8'h00, 8'h00, 8'h00},
    '{ROW_ITEM,  CFG_START_MARKER, 8'h0F, 8'd255, 1'b1, 8'hFF, 8'h00, 8'd255}
  };

  logic [CFG_IDX_W-1:0] reg_list [4] = '{CFG_START_MARKER, CFG_NODE_ADDRESS,
                                        CFG_END_MARKER, CFG_SPARE};

  function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = acc ^ b;
    repeat (BYTE_W) c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 79);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'($urandom_range(65, 255));
    if (r < 50) return 8'($urandom_range(1, 4));
    if (r < 75) return 8'($urandom_range(5, 16));
    return 8'($urandom_range(17, 64));
  endfunction

  task automatic predict_framing(input logic [BYTE_W-1:0] data, input logic [BYTE_W-1:0] len,
                                 input logic typed, input logic [BYTE_W-1:0] t_start,
                                 input logic [BYTE_W-1:0] t_addr,
                                 input logic [BYTE_W-1:0] t_len);
    logic [BYTE_W-1:0] l;
    if (!fr_open) begin
      l = (len == 8'd0) ? 8'd1 : len;
      fr_crc = crc8_step(crc8_step(CRC_INIT, reg_addr), l);
      pending_beats.push_back('{typed ? t_start : reg_start, 1'b0, 1'b0});
      pending_beats.push_back('{typed ? t_addr : reg_addr, 1'b0, 1'b0});
      pending_beats.push_back('{typed ? t_len : l, 1'b0, 1'b0});
      fr_left = l;
      fr_open = 1'b1;
    end
    fr_crc = crc8_step(fr_crc, data);
    fr_left = fr_left - 8'd1;
    if (fr_left == 8'd0) begin
      pending_beats.push_back('{data, 1'b0, 1'b0});
      pending_beats.push_back('{fr_crc, 1'b0, 1'b0});
      pending_beats.push_back('{reg_end, 1'b1, 1'b1});
      fr_open = 1'b0;
    end else begin
      pending_beats.push_back('{data, 1'b0, 1'b1});
    end
  endtask

  task automatic send_item(input logic [BYTE_W-1:0] data, input logic [BYTE_W-1:0] len,
                           input logic typed, input logic [BYTE_W-1:0] t_start,
                           input logic [BYTE_W-1:0] t_addr, input logic [BYTE_W-1:0] t_len);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    payload_byte <= data;
    frame_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_framing(data, len, typed, t_start, t_addr, t_len);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_START_MARKER: reg_start = val;
      CFG_NODE_ADDRESS: reg_addr = val;
      CFG_END_MARKER:   reg_end = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // receiver: random hold-off per beat, one long hold to back the block up
  initial begin
    int gap;
    int taken;
    logic held;
    taken = 0;
    held = 1'b0;
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 12);
      if (!held && taken >= HOLD_AT_BEAT && in_valid) begin
        gap = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  always @(posedge clk) begin
    beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: out_byte %02h frame_done %0b run_last %0b",
               out_byte, frame_done, run_last);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_byte);
          errors++;
        end
        if (frame_done !== want.done) begin
          $error("frame_done: expected %0b, got %0b", want.done, frame_done);
          errors++;
        end
        if (run_last !== want.last) begin
          $error("run_last: expected %0b, got %0b", want.last, run_last);
          errors++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] val;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_START_MARKER;
    cfg_data <= 8'h00;
    in_valid <= 1'b0;
    payload_byte <= 8'h00;
    frame_length <= 8'h00;
    reg_start = START_MARKER_RST;
    reg_addr = NODE_ADDRESS_RST;
    reg_end = END_MARKER_RST;
    fr_open = 1'b0;
    fr_left = 8'd0;
    fr_crc = CRC_INIT;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_item(plan[i].data, plan[i].len, plan[i].typed,
                  plan[i].t_start, plan[i].t_addr, plan[i].t_len);
      end
    end

    while (items_sent < ITEM_TARGET) begin
      drain();
      calm = ($urandom_range(0, 3) == 0);
      foreach (reg_list[k]) begin
        if ($urandom_range(0, 1) == 1) begin
          case ($urandom_range(0, 3))
            0: val = 8'h00;
            1: val = 8'hFF;
            default: val = 8'($urandom);
          endcase
          write_reg(reg_list[k], val);
        end
      end
      repeat ($urandom_range(8, 40)) begin
        len = fr_open ? 8'($urandom) : pick_length();
        send_item(8'($urandom), len, 1'b0, 8'h00, 8'h00, 8'h00);
      end
    end
    drain();
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
